### hw/rtl/sgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted group max-by-key block.
// No dependencies; used by sgm_cell and sorted_group_max_by_key_top.

package sgm_pkg;

  localparam int KEY_W            = 31;
  localparam int GRADE_W          = 16;
  localparam int COUNT_W          = 7;
  localparam int MAX_KEYS_DEFAULT = 64;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_UPDATE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sgm_state_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] best;
  } cell_link_t;

  typedef struct packed {
    cell_op_e           op;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
  } cell_cmd_t;

endpackage

### hw/rtl/sgm_cell.sv
`timescale 1ns / 1ps
// One entry of the sorted insertion chain: a key, its best grade and a valid bit.
// Depends on sgm_pkg for the command and neighbor link types.

module sgm_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sgm_pkg::cell_cmd_t    cmd_i,
  input  sgm_pkg::cell_link_t   left_i,
  input  logic                  left_gt_i,
  input  sgm_pkg::cell_link_t   right_i,
  output sgm_pkg::cell_link_t   link_o,
  output logic                  gt_o,
  output logic                  eq_o
);

  logic                          valid_q, valid_d;
  logic [sgm_pkg::KEY_W-1:0]     key_q, key_d;
  logic [sgm_pkg::GRADE_W-1:0]   best_q, best_d;

  assign gt_o = valid_q && (key_q > cmd_i.key);
  assign eq_o = valid_q && (key_q == cmd_i.key);

  assign link_o.valid = valid_q;
  assign link_o.key   = key_q;
  assign link_o.best  = best_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    best_d  = best_q;
    case (cmd_i.op)
      sgm_pkg::CELL_INSERT: begin
        if (gt_o || (!valid_q && left_i.valid)) begin
          valid_d = 1'b1;
          if (left_gt_i) begin
            key_d  = left_i.key;
            best_d = left_i.best;
          end else begin
            key_d  = cmd_i.key;
            best_d = cmd_i.grade;
          end
        end
      end
      sgm_pkg::CELL_UPDATE: begin
        if (eq_o && (cmd_i.grade > best_q)) begin
          best_d = cmd_i.grade;
        end
      end
      sgm_pkg::CELL_SHIFT: begin
        valid_d = right_i.valid;
        key_d   = right_i.key;
        best_d  = right_i.best;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    best_q <= best_d;
  end

endmodule

### hw/rtl/sorted_group_max_by_key_top.sv
`timescale 1ns / 1ps
// Top level of the sorted group max-by-key block: insertion chain, control, output register.
// Depends on sgm_pkg and sgm_cell.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------------
//  in      | in_valid_i/in_ready_o | account_i, grade_i, last_item_i
//  out     | out_valid_o/out_ready_i | key_out_o, best_grade_o, distinct_count_o,
//          |                       | overflow_o, last_result_o
//
// A new account is inserted as every cell compares its key against the broadcast account
// and the chain shifts right by one place at the insertion point (dropped if the chain is full).
// After the final pair of a set, the chain shifts left one entry per cycle, unless the output
// stalls, into the output register; in_ready_o stays low for the drain.
// Output stalls hold the drain. Reset clears valid bits, counters and state only.

module sorted_group_max_by_key_top #(
  parameter int MAX_KEYS = sgm_pkg::MAX_KEYS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sgm_pkg::KEY_W-1:0]     account_i,
  input  logic [sgm_pkg::GRADE_W-1:0]   grade_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sgm_pkg::KEY_W-1:0]     key_out_o,
  output logic [sgm_pkg::GRADE_W-1:0]   best_grade_o,
  output logic [sgm_pkg::COUNT_W-1:0]   distinct_count_o,
  output logic                          overflow_o,
  output logic                          last_result_o
);

  localparam int CntW    = $clog2(MAX_KEYS + 1);
  localparam int OutCntW = sgm_pkg::COUNT_W;

  sgm_pkg::sgm_state_e   state_q, state_d;
  logic [CntW-1:0]       used_q, used_d;
  logic                  dropped_q, dropped_d;
  logic [CntW-1:0]       run_count_q, run_count_d;
  logic                  run_drop_q, run_drop_d;
  logic                  out_valid_q, out_valid_d;
  logic [sgm_pkg::KEY_W-1:0]   key_out_q, key_out_d;
  logic [sgm_pkg::GRADE_W-1:0] best_out_q, best_out_d;
  logic [OutCntW-1:0]    cnt_out_q, cnt_out_d;
  logic                  ovf_out_q, ovf_out_d;
  logic                  last_out_q, last_out_d;

  sgm_pkg::cell_cmd_t    cmd;
  sgm_pkg::cell_link_t   link_w [MAX_KEYS];
  logic [MAX_KEYS-1:0]   gt_w;
  logic [MAX_KEYS-1:0]   eq_w;
  logic                  any_eq;
  logic                  full;
  logic                  accept;
  logic                  drain_step;
  logic                  insert_new;
  logic                  drop_new;

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    sgm_pkg::cell_link_t left_l;
    sgm_pkg::cell_link_t right_l;
    logic                left_gt;

    if (i == 0) begin : g_head
      assign left_l  = '{valid: 1'b1, key: '0, best: '0};
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_l  = link_w[i-1];
      assign left_gt = gt_w[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_tail
      assign right_l = '{valid: 1'b0, key: '0, best: '0};
    end else begin : g_mid
      assign right_l = link_w[i+1];
    end

    sgm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_l),
      .left_gt_i (left_gt),
      .right_i   (right_l),
      .link_o    (link_w[i]),
      .gt_o      (gt_w[i]),
      .eq_o      (eq_w[i])
    );
  end

  assign any_eq     = |eq_w;
  assign full       = (used_q == CntW'(MAX_KEYS));
  assign in_ready_o = (state_q == sgm_pkg::ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign drain_step = (state_q == sgm_pkg::ST_DRAIN) && (!out_valid_q || out_ready_i);
  assign insert_new = accept && !any_eq && !full;
  assign drop_new   = accept && !any_eq && full;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    dropped_d   = dropped_q;
    run_count_d = run_count_q;
    run_drop_d  = run_drop_q;
    out_valid_d = out_valid_q;
    key_out_d   = key_out_q;
    best_out_d  = best_out_q;
    cnt_out_d   = cnt_out_q;
    ovf_out_d   = ovf_out_q;
    last_out_d  = last_out_q;
    cmd.key     = account_i;
    cmd.grade   = grade_i;
    cmd.op      = sgm_pkg::CELL_HOLD;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      sgm_pkg::ST_LOAD: begin
        if (accept) begin
          if (any_eq) begin
            cmd.op = sgm_pkg::CELL_UPDATE;
          end else if (!full) begin
            cmd.op = sgm_pkg::CELL_INSERT;
          end
          used_d    = used_q + CntW'(insert_new);
          dropped_d = dropped_q | drop_new;
          if (last_item_i) begin
            run_count_d = used_q + CntW'(insert_new);
            run_drop_d  = dropped_q | drop_new;
            used_d      = '0;
            dropped_d   = 1'b0;
            state_d     = sgm_pkg::ST_DRAIN;
          end
        end
      end
      sgm_pkg::ST_DRAIN: begin
        if (drain_step) begin
          cmd.op      = sgm_pkg::CELL_SHIFT;
          out_valid_d = 1'b1;
          key_out_d   = link_w[0].key;
          best_out_d  = link_w[0].best;
          cnt_out_d   = OutCntW'(run_count_q);
          ovf_out_d   = run_drop_q;
          last_out_d  = !link_w[1].valid;
          if (!link_w[1].valid) begin
            state_d = sgm_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = sgm_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgm_pkg::ST_LOAD;
      used_q      <= '0;
      dropped_q   <= 1'b0;
      run_count_q <= '0;
      run_drop_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      dropped_q   <= dropped_d;
      run_count_q <= run_count_d;
      run_drop_q  <= run_drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_out_q  <= key_out_d;
    best_out_q <= best_out_d;
    cnt_out_q  <= cnt_out_d;
    ovf_out_q  <= ovf_out_d;
    last_out_q <= last_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign key_out_o        = key_out_q;
  assign best_grade_o     = best_out_q;
  assign distinct_count_o = cnt_out_q;
  assign overflow_o       = ovf_out_q;
  assign last_result_o    = last_out_q;

endmodule

### sim/sorted_group_max_by_key_top_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_group_max_by_key_top: random and directed sets of pairs,
// a grade tracker that predicts the sorted per-account maxima, random stalls on both sides.
// Depends on sgm_pkg and the sorted_group_max_by_key_top RTL.

module sorted_group_max_by_key_top_tb;

  localparam int KEY_W            = sgm_pkg::KEY_W;
  localparam int GRADE_W          = sgm_pkg::GRADE_W;
  localparam int COUNT_W          = sgm_pkg::COUNT_W;
  localparam int MAX_KEYS_DEFAULT = sgm_pkg::MAX_KEYS_DEFAULT;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] best;
    logic [COUNT_W-1:0] count;
    logic               overflow;
    logic               last;
  } grade_summary_t;

  class account_grade_tracker;
    logic [KEY_W-1:0]   kept_key [0:MAX_KEYS_DEFAULT-1];
    logic [GRADE_W-1:0] kept_best[0:MAX_KEYS_DEFAULT-1];
    int                 kept;
    bit                 dropped;
    int                 mismatches;
    grade_summary_t     expected_summaries[$];

    function new();
      kept = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    function void absorb_pair(logic [KEY_W-1:0] acct, logic [GRADE_W-1:0] grade,
                              logic last);
      int             pos;
      int             i;
      grade_summary_t s;
      pos = 0;
      while (pos < kept && kept_key[pos] < acct) pos++;
      if (pos < kept && kept_key[pos] == acct) begin
        if (grade > kept_best[pos]) kept_best[pos] = grade;
      end else if (kept >= MAX_KEYS_DEFAULT) begin
        dropped = 1;
      end else begin
        for (i = kept; i > pos; i--) begin
          kept_key[i]  = kept_key[i-1];
          kept_best[i] = kept_best[i-1];
        end
        kept_key[pos]  = acct;
        kept_best[pos] = grade;
        kept++;
      end
      if (last) begin
        for (i = 0; i < kept; i++) begin
          s.key      = kept_key[i];
          s.best     = kept_best[i];
          s.count    = COUNT_W'(kept);
          s.overflow = dropped;
          s.last     = (i == kept - 1);
          expected_summaries.push_back(s);
        end
        kept = 0;
        dropped = 0;
      end
    endfunction

    function void check_summary(grade_summary_t got);
      grade_summary_t exp;
      if (expected_summaries.size() == 0) begin
        $display("%0t: unexpected result key %h best %h count %0d ovf %b last %b",
                 $time, got.key, got.best, got.count, got.overflow, got.last);
        mismatches++;
      end else begin
        exp = expected_summaries.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch expected key %h best %h count %0d ovf %b last %b",
                   $time, exp.key, exp.best, exp.count, exp.overflow, exp.last);
          $display("%0t:          actual   key %h best %h count %0d ovf %b last %b",
                   $time, got.key, got.best, got.count, got.overflow, got.last);
          mismatches++;
        end
      end
    endfunction
  endclass

  localparam int PAIRS_TARGET = 460;
  localparam int PHASE_LEN    = 154;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KEY_W-1:0]   account_i;
  logic [GRADE_W-1:0] grade_i;
  logic               last_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [KEY_W-1:0]   key_out_o;
  logic [GRADE_W-1:0] best_grade_o;
  logic [COUNT_W-1:0] distinct_count_o;
  logic               overflow_o;
  logic               last_result_o;

  account_grade_tracker tracker;
  int                   pairs_sent;
  int                   quiet_cycles;
  bit                   hold_done;

  sorted_group_max_by_key_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .account_i        (account_i),
    .grade_i          (grade_i),
    .last_item_i      (last_item_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_out_o        (key_out_o),
    .best_grade_o     (best_grade_o),
    .distinct_count_o (distinct_count_o),
    .overflow_o       (overflow_o),
    .last_result_o    (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int stall_phase();
    if (pairs_sent < PHASE_LEN) return 0;
    if (pairs_sent < 2 * PHASE_LEN) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (stall_phase())
      0:       return 26;
      1:       return 71;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (stall_phase())
      0:       return 71;
      1:       return 26;
      default: return 0;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_account();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [GRADE_W-1:0] rand_grade();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return GRADE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_pair(input logic [KEY_W-1:0] acct, input logic [GRADE_W-1:0] grade,
                           input logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    account_i   <= acct;
    grade_i     <= grade;
    last_item_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
  endtask

  task automatic send_small_set(input int n_pairs, input bit wide);
    logic [KEY_W-1:0] pool[0:7];
    int               j;
    for (j = 0; j < 8; j++) pool[j] = rand_account();
    for (j = 0; j < n_pairs; j++)
      send_pair(pool[$urandom_range(0, wide ? 7 : 2)], rand_grade(), j == n_pairs - 1);
  endtask

  // Aim to fill the store, then mix new accounts (dropped once full) with updates of kept ones.
  task automatic send_full_set(input int n_pairs);
    logic [KEY_W-1:0] seen[0:MAX_KEYS_DEFAULT-1];
    logic [KEY_W-1:0] acct;
    int               j;
    for (j = 0; j < n_pairs; j++) begin
      if (j < MAX_KEYS_DEFAULT || $urandom_range(0, 1)) acct = rand_account();
      else acct = seen[$urandom_range(0, MAX_KEYS_DEFAULT - 1)];
      if (j < MAX_KEYS_DEFAULT) seen[j] = acct;
      send_pair(acct, rand_grade(), j == n_pairs - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        tracker.absorb_pair(account_i, grade_i, last_item_i);
      if (out_valid_o && out_ready_i)
        tracker.check_summary({key_out_o, best_grade_o, distinct_count_o, overflow_o,
                               last_result_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && stall_phase() == 2 && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  initial begin
    int full_sets;
    tracker      = new();
    pairs_sent   = 0;
    quiet_cycles = 0;
    full_sets    = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    account_i    = '0;
    grade_i      = '0;
    last_item_i  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-pair set at the low extremes
    send_pair('0, '0, 1'b1);
    // duplicates: lower, equal and higher grades, extremes of both fields
    send_pair(31'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_pair(31'h0000_0000, 16'h0001, 1'b0);
    send_pair(31'h7FFF_FFFF, 16'h0000, 1'b0);
    send_pair(31'h0000_0000, 16'h0001, 1'b0);
    send_pair(31'h4000_0000, 16'h8000, 1'b0);
    send_pair(31'h0000_0000, 16'hFFFF, 1'b0);
    send_pair(31'h2AAA_AAAA, 16'h5555, 1'b1);
    // descending arrival order
    send_pair(31'd50, 16'h00FF, 1'b0);
    send_pair(31'd40, 16'h00FF, 1'b0);
    send_pair(31'd30, 16'h00FF, 1'b0);
    send_pair(31'd20, 16'h00FF, 1'b0);
    send_pair(31'd10, 16'h00FF, 1'b0);
    send_pair(31'd30, 16'h0100, 1'b1);
    // single-pair set at the high extremes
    send_pair(31'h7FFF_FFFF, 16'hFFFF, 1'b1);

    while (pairs_sent < PAIRS_TARGET) begin
      if (full_sets < 3 && pairs_sent >= full_sets * PHASE_LEN + 20) begin
        send_full_set($urandom_range(MAX_KEYS_DEFAULT + 2, MAX_KEYS_DEFAULT + 16));
        full_sets++;
      end else begin
        send_small_set($urandom_range(1, 12), $urandom_range(0, 1));
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (tracker.expected_summaries.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
